>>> sv/bbc_pkg.sv
// Shared types, codes and lookup functions for the bracket balance checker.
// No dependencies; bbc_front, bbc_back and the top level import this package.
package bbc_pkg;

   localparam int BBC_STACK_DEPTH = 32;
   localparam int BBC_LINE_BITS   = 16;
   localparam int BBC_QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
   localparam logic [7:0] CHAR_RSQUARE = 8'h5D;

   typedef enum logic [1:0] {
      KIND_PAREN  = 2'd0,
      KIND_BRACE  = 2'd1,
      KIND_SQUARE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_OPEN     = 3'd0,
      EV_MATCH    = 3'd1,
      EV_NO_OPEN  = 3'd2,
      EV_MISMATCH = 3'd3,
      EV_SUCCESS  = 3'd4,
      EV_UNCLOSED = 3'd5,
      EV_OVERFLOW = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      CLS_NEWLINE = 2'd0,
      CLS_OPEN    = 2'd1,
      CLS_CLOSE   = 2'd2,
      CLS_END     = 2'd3
   } class_type;

   typedef enum logic {
      BE_RUN   = 1'b0,
      BE_DRAIN = 1'b1
   } back_state_type;

   // One classified item between front and back
   typedef struct packed {
      class_type  cls;
      kind_type   kind;
      logic [7:0] sym;
   } entry_type;

   typedef struct packed {
      logic draining;
      logic halted;
      logic empty;
   } status_type;

   function automatic kind_type open_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CHAR_LPAREN:  k = KIND_PAREN;
         CHAR_LBRACE:  k = KIND_BRACE;
         CHAR_LSQUARE: k = KIND_SQUARE;
         default:      k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type close_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CHAR_RPAREN:  k = KIND_PAREN;
         CHAR_RBRACE:  k = KIND_BRACE;
         CHAR_RSQUARE: k = KIND_SQUARE;
         default:      k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] open_symbol(input kind_type k);
      logic [7:0] s;
      unique case (k)
         KIND_BRACE:  s = CHAR_LBRACE;
         KIND_SQUARE: s = CHAR_LSQUARE;
         default:     s = CHAR_LPAREN;
      endcase
      return s;
   endfunction

endpackage

>>> sv/bbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bbc_front.sv
// Front end: classifies text bytes, drops those with no effect, and queues the rest.
// Depends on bbc_pkg.
module bbc_front
   import bbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   output logic       q_valid,
   input  logic       q_pop,
   output entry_type  q_head
);

   localparam int PTR_W = $clog2(BBC_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(BBC_QUEUE_DEPTH + 1);

   entry_type        queue_ff [BBC_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   entry_type cls_entry;
   logic      keep;
   logic      push;
   logic      pop;
   kind_type  ok, ck;

   always_comb begin
      ok             = open_kind(req_tdata);
      ck             = close_kind(req_tdata);
      keep           = 1'b1;
      cls_entry.sym  = req_tdata;
      cls_entry.kind = KIND_NONE;
      cls_entry.cls  = CLS_END;
      priority if (req_tlast) begin
         cls_entry.cls = CLS_END;
      end else if (req_tdata == CHAR_NEWLINE) begin
         cls_entry.cls = CLS_NEWLINE;
      end else if (ok != KIND_NONE) begin
         cls_entry.cls  = CLS_OPEN;
         cls_entry.kind = ok;
      end else if (ck != KIND_NONE) begin
         cls_entry.cls  = CLS_CLOSE;
         cls_entry.kind = ck;
      end else begin
         keep = 1'b0;
      end
   end

   assign req_tready = (fill_ff != CNT_W'(BBC_QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = q_pop && q_valid;
   assign q_valid    = (fill_ff != '0);
   assign q_head     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = CNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls_entry;
      end
   end

endmodule

>>> sv/bbc_back.sv
// Back end: line counter, bracket stack, halt flag, end-of-text drain, result register.
// Depends on bbc_pkg and bbc_ram.
module bbc_back
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = BBC_STACK_DEPTH,
   parameter int LINE_BITS   = BBC_LINE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_pop,
   input  entry_type   q_head,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   output status_type  status
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int RAM_W = LINE_BITS + 2;

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 halted_ff, halted_in;
   logic                 push_last_ff, push_last_in;
   logic [RAM_W-1:0]     push_data_ff;

   logic                 out_valid_ff, out_valid_in;
   event_type            ev_ff, ev_in;
   logic [7:0]           sym_ff, sym_in;
   logic [15:0]          sline_ff, sline_in;
   logic [7:0]           psym_ff, psym_in;
   logic [15:0]          pline_ff, pline_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 emit;
   logic                 go;
   logic                 wr_en;
   logic [RAM_W-1:0]     wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [RAM_W-1:0]     rd_data;
   logic [RAM_W-1:0]     top;
   kind_type             top_kind;
   logic [LINE_BITS-1:0] top_line;
   logic                 is_end;

   bbc_ram #(
      .WIDTH(RAM_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // RAM read is read-first; the entry pushed last cycle is served from a bypass
   assign top      = push_last_ff ? push_data_ff : rd_data;
   assign top_kind = kind_type'(top[RAM_W-1 -: 2]);
   assign top_line = top[LINE_BITS-1:0];
   assign wr_data  = {q_head.kind, line_ff};
   assign out_free = !out_valid_ff || rsp_tready;
   assign is_end   = (q_head.cls == CLS_END);
   assign go       = q_valid && (out_free || halted_ff || q_head.cls == CLS_NEWLINE);
   assign rd_addr  = (count_in == '0) ? '0 : IDX_W'(count_in - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_RUN: begin
            if (go && is_end && !halted_ff && count_ff != '0) begin
               state_in = BE_DRAIN;
            end
         end
         BE_DRAIN: begin
            if (out_free && count_ff == CNT_W'(1)) begin
               state_in = BE_RUN;
            end
         end
         default: state_in = BE_RUN;
      endcase
   end

   // datapath and results
   always_comb begin
      q_pop        = 1'b0;
      emit         = 1'b0;
      wr_en        = 1'b0;
      push_last_in = 1'b0;
      count_in     = count_ff;
      line_in      = line_ff;
      halted_in    = halted_ff;
      ev_in        = EV_OPEN;
      sym_in       = q_head.sym;
      sline_in     = 16'(line_ff);
      psym_in      = '0;
      pline_in     = '0;
      last_in      = 1'b1;
      unique case (state_ff)
         BE_RUN: begin
            if (go) begin
               q_pop = 1'b1;
               if (halted_ff) begin
                  if (is_end) begin
                     count_in  = '0;
                     line_in   = LINE_BITS'(1);
                     halted_in = 1'b0;
                  end
               end else begin
                  unique case (q_head.cls)
                     CLS_NEWLINE: begin
                        if (line_ff != '1) begin
                           line_in = LINE_BITS'(line_ff + 1'b1);
                        end
                     end
                     CLS_OPEN: begin
                        emit = 1'b1;
                        if (count_ff == CNT_W'(STACK_DEPTH)) begin
                           ev_in     = EV_OVERFLOW;
                           halted_in = 1'b1;
                        end else begin
                           ev_in        = EV_OPEN;
                           wr_en        = 1'b1;
                           push_last_in = 1'b1;
                           count_in     = CNT_W'(count_ff + 1'b1);
                        end
                     end
                     CLS_CLOSE: begin
                        emit = 1'b1;
                        if (count_ff == '0) begin
                           ev_in     = EV_NO_OPEN;
                           sline_in  = '0;
                           halted_in = 1'b1;
                        end else begin
                           count_in = CNT_W'(count_ff - 1'b1);
                           psym_in  = open_symbol(top_kind);
                           pline_in = 16'(top_line);
                           if (top_kind == q_head.kind) begin
                              ev_in = EV_MATCH;
                           end else begin
                              ev_in     = EV_MISMATCH;
                              halted_in = 1'b1;
                           end
                        end
                     end
                     CLS_END: begin
                        line_in = LINE_BITS'(1);
                        if (count_ff == '0) begin
                           emit     = 1'b1;
                           ev_in    = EV_SUCCESS;
                           sym_in   = '0;
                           sline_in = '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         BE_DRAIN: begin
            if (out_free) begin
               emit     = 1'b1;
               ev_in    = EV_UNCLOSED;
               sym_in   = open_symbol(top_kind);
               sline_in = 16'(top_line);
               last_in  = (count_ff == CNT_W'(1));
               count_in = CNT_W'(count_ff - 1'b1);
            end
         end
         default: ;
      endcase
      out_valid_in = emit || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_RUN;
         count_ff     <= '0;
         line_ff      <= LINE_BITS'(1);
         halted_ff    <= 1'b0;
         push_last_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         line_ff      <= line_in;
         halted_ff    <= halted_in;
         push_last_ff <= push_last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_last_in) begin
         push_data_ff <= wr_data;
      end
      if (emit) begin
         ev_ff    <= ev_in;
         sym_ff   <= sym_in;
         sline_ff <= sline_in;
         psym_ff  <= psym_in;
         pline_ff <= pline_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {pline_ff, psym_ff, sline_ff, sym_ff};
   assign rsp_tuser  = ev_ff;
   assign rsp_tlast  = last_ff;

   assign status.draining = (state_ff == BE_DRAIN);
   assign status.halted   = halted_ff;
   assign status.empty    = (count_ff == '0);

endmodule

>>> sv/bracket_balance_checker.sv
// Top level of the bracket balance checker: front classifier/queue feeding the stack engine.
// Depends on bbc_pkg, bbc_front, bbc_back (and bbc_ram below it).
//
//  Channel  Dir  Fields (low bit first)
//  req_     in   tdata: char_code[7:0]; tlast: end_marker
//  rsp_     out  tdata: symbol, symbol_line, partner_symbol, partner_line;
//                tuser: event_kind; tlast: last_of_run
//
// One text byte per cycle is taken while the four-entry front queue has room.
// The back end handles brackets and newlines one at a time; brackets wait for a free output
// register, while newlines do not. The stack top is kept current through a registered-read RAM plus a one-entry bypass.
// An end item with N unclosed brackets is taken first, then one unclosed result is given per bracket.
// Reset empties the stack, sets the line to 1 and clears the halt flag.
// A stalled result holds in the output register; the front keeps filling meanwhile.
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = BBC_STACK_DEPTH,
   parameter int LINE_BITS   = BBC_LINE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // char_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // symbol, symbol_line, partner_symbol, partner_line
   output logic [2:0]  rsp_tuser,  // event_kind
   output logic        rsp_tlast
);

   logic       q_valid;
   logic       q_pop;
   entry_type  q_head;
   status_type status;

   bbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head)
   );

   bbc_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .LINE_BITS  (LINE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .status    (status)
   );

   // drain only runs with brackets left on the stack
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      status.draining |-> !status.empty)
      else $error("drain with empty stack");

   // drain is only entered from an end item taken while not halted
   a_drain_not_halted: assert property (@(posedge clock) disable iff (reset)
      status.draining |-> !status.halted)
      else $error("drain while halted");

   // only unclosed reports can be non-final in their run
   a_last_only_unclosed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == EV_UNCLOSED)
      else $error("non-final result that is not an unclosed report");

   // no queue pops while the stack is being drained
   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.draining |-> !q_pop)
      else $error("queue pop during drain");

endmodule
